[hdl/ca_row_propagation_pixel_blend_assert.svh]
// Assertion macros for the row propagation pixel blend block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef CA_ROW_PROPAGATION_PIXEL_BLEND_ASSERT_SVH
`define CA_ROW_PROPAGATION_PIXEL_BLEND_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CARPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CARPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/carpb_pkg.sv]
// Package for the row propagation pixel blend block.
// Holds payload structs, register indexes and fixed constants; no dependencies.
`timescale 1ns / 1ps

package carpb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  // Width used for the extended row and column comparisons (holds counts up to 4096 plus two).
  localparam int CMP_W      = 13;

  localparam logic [8:0] MIX_ONE = 9'd256;
  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_OVERLAY_MIX  = 3'd1,
    REG_DRAW_MIX     = 3'd2,
    REG_RULE_BITS    = 3'd3,
    REG_LINE_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT = 3'd5
  } cfg_reg_t;

  localparam logic [7:0]  RST_THRESHOLD    = 8'd64;
  localparam logic [8:0]  RST_OVERLAY_MIX  = 9'd256;
  localparam logic [8:0]  RST_DRAW_MIX     = 9'd256;
  localparam logic [7:0]  RST_RULE_BITS    = 8'd30;
  localparam logic [11:0] RST_LINE_WIDTH   = 12'd1280;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd720;

  typedef struct packed {
    logic [7:0] target_pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [9:0]  out_row;
    logic [10:0] out_col;
    logic        frame_last;
  } out_item_t;

endpackage

[hdl/ca_row_propagation_pixel_blend.sv]
// Row propagation of an elementary cellular automaton over a gray pixel stream.
// Depends on carpb_pkg and on ca_row_propagation_pixel_blend_assert.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | input     | in_valid / in_stall   | carpb_pkg::in_item_t
//  out     | output    | out_valid / out_stall | carpb_pkg::out_item_t
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel is taken every cycle while in_stall is low; its result, if any, is
// registered in the middle stage and then in the output register. The line store is
// one memory with one read and one write per cycle. Reset is synchronous and needs
// no clearing pass: a per-frame written-column mark makes unwritten columns read as
// zero. When the output register is full and stalled, an item holding a result waits
// in the middle stage and the input stalls; items that give no result keep moving.
`timescale 1ns / 1ps

module ca_row_propagation_pixel_blend #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  carpb_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output carpb_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [carpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [carpb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int KW = carpb_pkg::CMP_W;

  typedef struct packed {
    logic [7:0]    tgt;
    logic          clr;
    logic          drw_vld;
    logic          res;
    logic [CW-1:0] wcol;
    logic [9:0]    row;
    logic [10:0]   col;
    logic          last;
  } s1_item_t;

  // Blend of target and drawn pixel, compared with the threshold.
  function automatic logic cell_f(input logic [7:0] t, input logic [7:0] d,
                                  input logic [8:0] om, input logic [7:0] th);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    logic signed [10:0] blend;
    diff  = $signed({2'b00, d}) - $signed({2'b00, t});
    prod  = diff * $signed({1'b0, om});
    blend = $signed({3'b000, t}) + $signed(prod[18:8]);
    return blend[7:0] >= th;
  endfunction

  // Configuration registers.
  logic [7:0]  threshold_r;
  logic [8:0]  overlay_mix_r;
  logic [8:0]  draw_mix_r;
  logic [7:0]  rule_bits_r;
  logic [11:0] line_width_r;
  logic [10:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= carpb_pkg::RST_THRESHOLD;
      overlay_mix_r  <= carpb_pkg::RST_OVERLAY_MIX;
      draw_mix_r     <= carpb_pkg::RST_DRAW_MIX;
      rule_bits_r    <= carpb_pkg::RST_RULE_BITS;
      line_width_r   <= carpb_pkg::RST_LINE_WIDTH;
      frame_height_r <= carpb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        carpb_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[7:0];
        carpb_pkg::REG_OVERLAY_MIX:  overlay_mix_r  <= cfg_data[8:0];
        carpb_pkg::REG_DRAW_MIX:     draw_mix_r     <= cfg_data[8:0];
        carpb_pkg::REG_RULE_BITS:    rule_bits_r    <= cfg_data[7:0];
        carpb_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_data[11:0];
        carpb_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and saturated mixes.
  logic [KW-1:0] lw_ext, fh_ext, w_eff, h_eff;
  logic [8:0]    om_sat, dm_sat;

  always_comb begin
    lw_ext = KW'(line_width_r);
    fh_ext = KW'(frame_height_r);
    if (lw_ext < KW'(3))              w_eff = KW'(3);
    else if (lw_ext > KW'(MAX_WIDTH)) w_eff = KW'(MAX_WIDTH);
    else                              w_eff = lw_ext;
    if (fh_ext < KW'(2))               h_eff = KW'(2);
    else if (fh_ext > KW'(MAX_HEIGHT)) h_eff = KW'(MAX_HEIGHT);
    else                               h_eff = fh_ext;
    om_sat = (overlay_mix_r > carpb_pkg::MIX_ONE) ? carpb_pkg::MIX_ONE : overlay_mix_r;
    dm_sat = (draw_mix_r > carpb_pkg::MIX_ONE) ? carpb_pkg::MIX_ONE : draw_mix_r;
  end

  // Pipeline control.
  logic     s1_valid_r;
  s1_item_t s1_r;
  logic     out_valid_r;
  logic     out_free, s1_go, acc, wr_en;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (out_free || !s1_r.res);
  assign in_stall = s1_valid_r && !s1_go;
  assign acc      = in_valid && !in_stall;
  assign wr_en    = s1_go && s1_r.res;

  // Intake: position counters and line store read address.
  logic [CW-1:0] col_r, col_nxt, c0;
  logic [RW-1:0] row_r, row_nxt, r0;
  logic [CW-1:0] hw_r, hw_nxt;
  logic [KW-1:0] c_ext, r_ext;
  logic          clr0, end_row;
  s1_item_t      s1_nxt;

  always_comb begin
    clr0    = in_data.frame_start || (row_r == '0 && col_r == '0);
    c0      = clr0 ? '0 : col_r;
    r0      = clr0 ? '0 : row_r;
    c_ext   = KW'(c0);
    r_ext   = KW'(r0);
    end_row = (c_ext + KW'(1)) >= w_eff;
    col_nxt = end_row ? '0 : c0 + CW'(1);
    if (end_row) row_nxt = ((r_ext + KW'(1)) >= h_eff) ? '0 : r0 + RW'(1);
    else         row_nxt = r0;

    s1_nxt.tgt     = in_data.target_pixel;
    s1_nxt.clr     = clr0;
    // Columns written in this frame always form the range 1 .. hw_r.
    s1_nxt.drw_vld = !clr0 && (c0 != '0) && (c0 <= hw_r);
    s1_nxt.res     = (c_ext >= KW'(2)) && ((r_ext + KW'(1)) < h_eff);
    s1_nxt.wcol    = c0 - CW'(1);
    s1_nxt.row     = 10'(r_ext + KW'(1));
    s1_nxt.col     = 11'(c_ext - KW'(1));
    s1_nxt.last    = ((r_ext + KW'(2)) >= h_eff) && end_row;

    // A frame clear wins over the last write of the previous frame.
    if (acc && clr0)                    hw_nxt = '0;
    else if (wr_en && s1_r.wcol > hw_r) hw_nxt = s1_r.wcol;
    else                                hw_nxt = hw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      hw_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      hw_r <= hw_nxt;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (acc)        s1_valid_r <= 1'b1;
      else if (s1_go) s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Line store of the drawn row above.
  logic [7:0] draw_mem [MAX_WIDTH];
  logic [7:0] rd_data_r;
  logic [7:0] pix;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      draw_mem[s1_r.wcol] <= pix;
    end
    if (acc) begin
      rd_data_r <= draw_mem[c0];
    end
  end

  // Neighborhood windows and the automaton step.
  logic [7:0]  tw0_r, tw1_r, dw0_r, dw1_r;
  logic [7:0]  tw0, tw1, dw0, dw1, drw;
  logic [2:0]  nb;
  logic        rule_bit;
  logic [16:0] pix_sum;

  always_comb begin
    tw0   = s1_r.clr ? '0 : tw0_r;
    tw1   = s1_r.clr ? '0 : tw1_r;
    dw0   = s1_r.clr ? '0 : dw0_r;
    dw1   = s1_r.clr ? '0 : dw1_r;
    drw   = s1_r.drw_vld ? rd_data_r : '0;
    nb    = {cell_f(tw0, dw0, om_sat, threshold_r),
             cell_f(tw1, dw1, om_sat, threshold_r),
             cell_f(s1_r.tgt, drw, om_sat, threshold_r)};
    rule_bit = rule_bits_r[nb];
    pix_sum  = 17'(dw1) * 17'(dm_sat)
             + (rule_bit ? 17'(carpb_pkg::PIX_MAX) * 17'(carpb_pkg::MIX_ONE - dm_sat)
                         : 17'd0);
    pix      = pix_sum[15:8];
  end

  // Windows only need valid contents after a clearing item, which the first item is.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      tw0_r <= tw1;
      tw1_r <= s1_r.tgt;
      dw0_r <= dw1;
      dw1_r <= drw;
    end
  end

  // Output register.
  carpb_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && wr_en) begin
      out_data_r.pixel_value <= pix;
      out_data_r.out_row     <= s1_r.row;
      out_data_r.out_col     <= s1_r.col;
      out_data_r.frame_last  <= s1_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "ca_row_propagation_pixel_blend_assert.svh"

  `CARPB_ASSERT_NOW(a_no_rw_collision, acc && wr_en, c0 != s1_r.wcol,
                    "line store read and write hit the same column")
  `CARPB_ASSERT_NOW(a_held_result_stalls_input,
                    s1_valid_r && s1_r.res && out_valid_r && out_stall, in_stall,
                    "input taken while a result is blocked in the middle stage")
  `CARPB_ASSERT_NEXT(a_clear_resets_mark, acc && clr0, hw_r == '0,
                     "written-column mark not cleared at frame start")

endmodule
